// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property must never hold at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// File: hw/rtl/gtt_pkg.sv
// ----------------------------------------------------------------------------
// gtt_pkg
// types and constants of the grammar text tokenizer
// ----------------------------------------------------------------------------
package gtt_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned OutPosW  = 16;
  localparam int unsigned InDataW  = CharW;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = CharW + 2 * OutPosW;
  localparam int unsigned KindW    = 4;

  localparam logic [CharW-1:0] ChColon   = 8'h3A;
  localparam logic [CharW-1:0] ChBar     = 8'h7C;
  localparam logic [CharW-1:0] ChSemi    = 8'h3B;
  localparam logic [CharW-1:0] ChHash    = 8'h23;
  localparam logic [CharW-1:0] ChUscore  = 8'h5F;
  localparam logic [CharW-1:0] ChQuote   = 8'h27;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;

  typedef enum logic [2:0] {
    ModeBetween = 3'd0,
    ModeName    = 3'd1,
    ModeString  = 3'd2,
    ModeComment = 3'd3,
    ModeEnded   = 3'd4
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KindNameCh     = 4'd0,
    KindNameEnd    = 4'd1,
    KindStrCh      = 4'd2,
    KindStrEnd     = 4'd3,
    KindColon      = 4'd4,
    KindBar        = 4'd5,
    KindSemi       = 4'd6,
    KindNewline    = 4'd7,
    KindEnd        = 4'd8,
    KindUnterm     = 4'd9,
    KindEmpty      = 4'd10,
    KindUnexpected = 4'd11
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CharW-1:0]   chr;
    logic [OutPosW-1:0] row;
    logic [OutPosW-1:0] col;
    logic               last;
  } res_t;

  function automatic logic is_letter(input logic [CharW-1:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == ChUscore);
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] b);
    return (b == ChSpace) || (b == ChTab);
  endfunction

endpackage

// File: hw/rtl/grammar_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// grammar_text_tokenizer_top
// streaming tokenizer: one text byte per request in, token events out
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                        tuser         tlast
//  s_axis    in   ch[7:0]                      at_end[0]     -
//  m_axis    out  char_out, token_row, col     kind[3:0]     last
//
//  - one input request is taken per cycle while s_axis_tready_o is high; its
//    events are written into a four-entry result queue at the same edge
//  - a request yields zero, one or two events; the queue drains one per
//    cycle while m_axis_tready_i is high, so only two-event requests (name end
//    plus next token, or end of input inside a name or string) can fill it faster
//  - s_axis_tready_o is high while the queue has room for two events,
//    so an accepted request never overfills the queue
//  - asynchronous active-low reset clears scan state, positions and queue
//  - after the end-of-input request every further request is taken and dropped
`include "assert_macros.svh"

module grammar_text_tokenizer_top #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [gtt_pkg::InDataW-1:0]   s_axis_tdata_i,   // [7:0] ch
  input  logic [gtt_pkg::InUserW-1:0]   s_axis_tuser_i,   // [0] at_end
  // event stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [gtt_pkg::OutDataW-1:0]  m_axis_tdata_o,   // [7:0] char_out,
                                                          // [23:8] token_row,
                                                          // [39:24] token_col
  output logic [gtt_pkg::KindW-1:0]     m_axis_tuser_o,   // [3:0] kind
  output logic                          m_axis_tlast_o    // last event of request
);
  import gtt_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  // scan state
  mode_e                    mode_q, mode_d;
  logic                     prev_nl_q, prev_nl_d;
  logic                     prev_blank_q, prev_blank_d;
  logic                     has_text_q, has_text_d;
  logic [POSITION_BITS-1:0] cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [POSITION_BITS-1:0] start_row_q, start_row_d, start_col_q, start_col_d;

  // positions clipped to the event width
  logic [OutPosW-1:0] cur_row_o, cur_col_o, start_row_o, start_col_o;

  generate
    if (POSITION_BITS > OutPosW) begin : g_clip
      localparam logic [POSITION_BITS-1:0] ClipMax = POSITION_BITS'(16'hFFFF);
      assign cur_row_o   = (cur_row_q   > ClipMax) ? '1 : cur_row_q[OutPosW-1:0];
      assign cur_col_o   = (cur_col_q   > ClipMax) ? '1 : cur_col_q[OutPosW-1:0];
      assign start_row_o = (start_row_q > ClipMax) ? '1 : start_row_q[OutPosW-1:0];
      assign start_col_o = (start_col_q > ClipMax) ? '1 : start_col_q[OutPosW-1:0];
    end else begin : g_ext
      assign cur_row_o   = OutPosW'(cur_row_q);
      assign cur_col_o   = OutPosW'(cur_col_q);
      assign start_row_o = OutPosW'(start_row_q);
      assign start_col_o = OutPosW'(start_col_q);
    end
  endgenerate

  // handshakes
  logic             in_acc, out_pop;
  logic [CharW-1:0] b;
  logic             at_end;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign b       = s_axis_tdata_i[CharW-1:0];
  assign at_end  = s_axis_tuser_i[0];
  assign s_axis_tready_o = (cnt_q <= QCntW'(QDepth - 2));
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop = m_axis_tvalid_o && m_axis_tready_i;

  // start of a new token from the between-tokens state
  logic  bt_emit;
  res_t  bt_res;
  mode_e bt_mode;
  logic  bt_load_start;
  logic  bt_clr_text;

  always_comb begin
    bt_emit       = 1'b0;
    bt_res        = '{kind: KindUnexpected, chr: '0, row: cur_row_o, col: cur_col_o,
                      last: 1'b0};
    bt_mode       = ModeBetween;
    bt_load_start = 1'b0;
    bt_clr_text   = 1'b0;
    if (is_blank(b)) begin
      bt_emit = 1'b0;
    end else if (b == ChNewline) begin
      // a newline run reports once
      bt_emit     = !prev_nl_q;
      bt_res.kind = KindNewline;
    end else if (b == ChHash) begin
      bt_mode = ModeComment;
    end else if (is_letter(b)) begin
      bt_mode       = ModeName;
      bt_load_start = 1'b1;
      bt_emit       = 1'b1;
      bt_res.kind   = KindNameCh;
      bt_res.chr    = b;
    end else if (b == ChColon) begin
      bt_emit     = 1'b1;
      bt_res.kind = KindColon;
    end else if (b == ChBar) begin
      bt_emit     = 1'b1;
      bt_res.kind = KindBar;
    end else if (b == ChSemi) begin
      bt_emit     = 1'b1;
      bt_res.kind = KindSemi;
    end else if (b == ChQuote) begin
      bt_mode       = ModeString;
      bt_load_start = 1'b1;
      bt_clr_text   = 1'b1;
    end else begin
      // byte that opens no token
      bt_emit = 1'b1;
    end
  end

  // per-request events and next scan state
  res_t       ev0, ev1;
  logic [1:0] n_ev;
  res_t       at_start, at_cur;

  always_comb begin
    at_start = '{kind: KindNameEnd, chr: '0, row: start_row_o, col: start_col_o, last: 1'b0};
    at_cur   = '{kind: KindEnd, chr: '0, row: cur_row_o, col: cur_col_o, last: 1'b0};
    ev0          = at_cur;
    ev1          = at_cur;
    n_ev         = 2'd0;
    mode_d       = mode_q;
    prev_nl_d    = prev_nl_q;
    prev_blank_d = prev_blank_q;
    has_text_d   = has_text_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    start_row_d  = start_row_q;
    start_col_d  = start_col_q;

    if (in_acc && mode_q != ModeEnded) begin
      if (at_end) begin
        // close an open name or string, then report end of input
        mode_d = ModeEnded;
        case (mode_q)
          ModeName: begin
            ev0  = at_start;
            n_ev = 2'd2;
          end
          ModeString: begin
            ev0      = at_start;
            ev0.kind = KindUnterm;
            n_ev     = 2'd2;
          end
          default: begin
            ev0  = at_cur;
            n_ev = 2'd1;
          end
        endcase
      end else begin
        case (mode_q)
          ModeName: begin
            if (is_letter(b)) begin
              ev0      = at_start;
              ev0.kind = KindNameCh;
              ev0.chr  = b;
              n_ev     = 2'd1;
            end else begin
              // name end, then the byte starts the next token
              ev0    = at_start;
              ev1    = bt_res;
              n_ev   = bt_emit ? 2'd2 : 2'd1;
              mode_d = bt_mode;
              if (bt_load_start) begin
                start_row_d = cur_row_q;
                start_col_d = cur_col_q;
              end
              if (bt_clr_text) begin
                has_text_d = 1'b0;
              end
            end
          end
          ModeString: begin
            ev0      = at_start;
            ev0.kind = KindStrCh;
            ev0.chr  = b;
            if (b == ChQuote) begin
              ev0.kind = has_text_q ? KindStrEnd : KindEmpty;
              ev0.chr  = '0;
              n_ev     = 2'd1;
              mode_d   = ModeBetween;
            end else if (is_blank(b)) begin
              // blank run kept as one space
              ev0.chr = ChSpace;
              if (!prev_blank_q) begin
                n_ev       = 2'd1;
                has_text_d = 1'b1;
              end
            end else if (b == ChNewline) begin
              if (!prev_nl_q) begin
                n_ev       = 2'd1;
                has_text_d = 1'b1;
              end
            end else begin
              n_ev       = 2'd1;
              has_text_d = 1'b1;
            end
          end
          ModeComment: begin
            if (b == ChNewline) begin
              ev0      = at_cur;
              ev0.kind = KindNewline;
              n_ev     = 2'd1;
              mode_d   = ModeBetween;
            end
          end
          default: begin
            ev0    = bt_res;
            n_ev   = bt_emit ? 2'd1 : 2'd0;
            mode_d = bt_mode;
            if (bt_load_start) begin
              start_row_d = cur_row_q;
              start_col_d = cur_col_q;
            end
            if (bt_clr_text) begin
              has_text_d = 1'b0;
            end
          end
        endcase

        // position tracking, saturating
        prev_nl_d    = (b == ChNewline);
        prev_blank_d = is_blank(b);
        if (b == ChNewline) begin
          if (cur_row_q != PosMax) begin
            cur_row_d = cur_row_q + POSITION_BITS'(1);
          end
          cur_col_d = '0;
        end else if (cur_col_q != PosMax) begin
          cur_col_d = cur_col_q + POSITION_BITS'(1);
        end
      end
    end

    ev0.last = (n_ev == 2'd1);
    ev1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeBetween;
      prev_nl_q    <= 1'b0;
      prev_blank_q <= 1'b0;
      has_text_q   <= 1'b0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      start_row_q  <= '0;
      start_col_q  <= '0;
    end else begin
      mode_q       <= mode_d;
      prev_nl_q    <= prev_nl_d;
      prev_blank_q <= prev_blank_d;
      has_text_q   <= has_text_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      start_row_q  <= start_row_d;
      start_col_q  <= start_col_d;
    end
  end

  // result queue: up to two writes, one read per cycle
  res_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  res_t             head;

  assign cnt_d = cnt_q + QCntW'(n_ev) - QCntW'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_ev);
      rd_ptr_q <= rd_ptr_q + QPtrW'(out_pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_ev != 2'd0) begin
      q_mem[wr_ptr_q] <= ev0;
    end
    if (n_ev == 2'd2) begin
      q_mem[wr_ptr_q + QPtrW'(1)] <= ev1;
    end
  end

  assign head            = q_mem[rd_ptr_q];
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {head.col, head.row, head.chr};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

  // checks
  `ASSERT_AT(a_q_bound, clk_i, rst_ni, cnt_q <= QCntW'(QDepth), "result queue overfilled")
  `ASSERT_AT(a_end_sticky, clk_i, rst_ni, (mode_q == ModeEnded) |=> (mode_q == ModeEnded), "scanner left ended state")
  `ASSERT_NEVER(a_end_last, clk_i, rst_ni, m_axis_tvalid_o && (head.kind == KindEnd) && !head.last, "end event not last of request")
  `ASSERT_NEVER(a_ended_silent, clk_i, rst_ni, (mode_q == ModeEnded) && (n_ev != 2'd0), "event after end of input")

endmodule
